// ----- hw/rtl/cluster_pair_invariant_mass_defines.svh -----
// Assertion macros for the cluster pair mass finder checker
`ifndef CLUSTER_PAIR_INVARIANT_MASS_DEFINES_SVH
`define CLUSTER_PAIR_INVARIANT_MASS_DEFINES_SVH

// same-cycle implication, inactive during reset
`define CPIM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, inactive during reset
`define CPIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cpim_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpim_pkg
// Shared constants and types for the cluster pair invariant mass finder.
// ----------------------------------------------------------------------------
package cpim_pkg;

  localparam int MAX_CLUSTERS = 32;
  localparam int SLOT_W       = $clog2(MAX_CLUSTERS);
  localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1);

  localparam int E_W   = 16;
  localparam int P_W   = 17;
  localparam int M_W   = 17;
  localparam int ENTRY_W = E_W + 3 * P_W;

  localparam int ROOT_STEPS = 17;
  localparam int DIV_STEPS  = 17;

  localparam logic [1:0] REG_MIN_ENERGY  = 2'd0;
  localparam logic [1:0] REG_WINDOW_LOW  = 2'd1;
  localparam logic [1:0] REG_WINDOW_HIGH = 2'd2;
  localparam logic [1:0] REG_UNUSED      = 2'd3;

  localparam logic [15:0] MIN_ENERGY_RST  = 16'd70;
  localparam logic [16:0] WINDOW_LOW_RST  = 17'd100;
  localparam logic [16:0] WINDOW_HIGH_RST = 17'd180;

  localparam logic KIND_PAIR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_READ  = 9'b000000010,
    ST_SUMS  = 9'b000000100,
    ST_SQR   = 9'b000001000,
    ST_ACC   = 9'b000010000,
    ST_ROOT  = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_EMIT  = 9'b010000000,
    ST_SUMRY = 9'b100000000
  } state_t;

endpackage

// ----- hw/rtl/cpim_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/cluster_pair_invariant_mass.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_pair_invariant_mass
// Pairs each kept calorimeter cluster with the earlier ones of its event.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: an item is taken when start is high and busy is low.
//    cluster_valid=0 marks an item with no cluster; last_in_event closes the event.
//  - Results appear for one cycle on result_valid; the receiver cannot stall,
//    so every result is taken in the cycle it is shown.
//  - A kept cluster with N earlier clusters gives N pair results, one after
//    another. Each pair passes read, sums, squares, accumulate, radicand load
//    plus 17-step bit-serial square root, window check and emit; in window,
//    a 17-step bit-serial asymmetry divide comes between check and emit.
//  - An item with no pairs but an event end goes to the summary state, which
//    registers its summary result; an item with no results leaves busy low,
//    so the next item can be taken at the following edge.
//  - Clusters sit in one 32-entry RAM; a new one is written at transfer if kept and the RAM is not full.
//  - The user writes configuration through wr_en/wr_index/wr_data only while idle; the block does not enforce it.
//  - Reset clears the event count, overflow flag and registers to defaults.
// ----------------------------------------------------------------------------
module cluster_pair_invariant_mass (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [16:0] wr_data,
  input  logic        start,
  output logic        busy,
  input  logic        cluster_valid,
  input  logic [15:0] energy,
  input  logic signed [16:0] mom_x,
  input  logic signed [16:0] mom_y,
  input  logic signed [16:0] mom_z,
  input  logic        last_in_event,
  output logic        result_valid,
  output logic        kind,
  output logic [16:0] pair_mass,
  output logic        in_window,
  output logic [15:0] asymmetry,
  output logic [4:0]  first_slot,
  output logic [4:0]  second_slot,
  output logic [5:0]  kept_count,
  output logic        overflow,
  output logic        last
);

  localparam int SW = cpim_pkg::SLOT_W;
  localparam int CW = cpim_pkg::CNT_W;

  cpim_pkg::state_t state;

  logic [15:0] min_energy;
  logic [16:0] window_low;
  logic [16:0] window_high;

  logic [CW-1:0] kept_total;
  logic          overflow_seen;

  // latched item
  logic [15:0]        cur_e;
  logic signed [16:0] cur_px, cur_py, cur_pz;
  logic               cur_last;
  logic [SW-1:0]      slot;
  logic [SW-1:0]      idx;

  logic               accept, keep, full, has_pairs;
  logic [cpim_pkg::ENTRY_W-1:0] rdata;

  // arithmetic pipeline
  logic [16:0]        et;
  logic signed [17:0] sx, sy, sz;
  logic [15:0]        de;
  logic [33:0]        et2;
  logic [34:0]        sx2, sy2, sz2;
  logic signed [36:0] m2;

  logic [33:0] rad;
  logic [19:0] rem;
  logic [16:0] root;
  logic [19:0] rem_sh, trial;

  logic [17:0] drem, dtrial;
  logic [16:0] quo;
  logic [4:0]  step;
  logic        inw;

  logic [15:0]        rd_e;
  logic signed [16:0] rd_px, rd_py, rd_pz;

  assign busy   = (state != cpim_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign keep   = cluster_valid && (energy >= min_energy);
  assign full   = (kept_total == CW'(cpim_pkg::MAX_CLUSTERS));
  assign has_pairs = keep && !full && (kept_total != '0);

  assign {rd_e, rd_px, rd_py, rd_pz} = rdata;

  cpim_ram #(
    .WIDTH (cpim_pkg::ENTRY_W),
    .DEPTH (cpim_pkg::MAX_CLUSTERS)
  ) u_store (
    .clk   (clk),
    .we    (accept && keep && !full),
    .waddr (kept_total[SW-1:0]),
    .wdata ({energy, mom_x, mom_y, mom_z}),
    .raddr (idx),
    .rdata (rdata)
  );

  assign rem_sh = {rem[17:0], rad[33:32]};
  assign trial  = {1'b0, root, 2'b01};
  // first divide step compares the unshifted difference
  assign dtrial = (step == 5'd1) ? drem : {drem[16:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_energy  <= cpim_pkg::MIN_ENERGY_RST;
      window_low  <= cpim_pkg::WINDOW_LOW_RST;
      window_high <= cpim_pkg::WINDOW_HIGH_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        cpim_pkg::REG_MIN_ENERGY:  min_energy  <= wr_data[15:0];
        cpim_pkg::REG_WINDOW_LOW:  window_low  <= wr_data;
        cpim_pkg::REG_WINDOW_HIGH: window_high <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cpim_pkg::ST_IDLE;
      kept_total    <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        cpim_pkg::ST_IDLE: begin
          if (accept) begin
            cur_e    <= energy;
            cur_px   <= mom_x;
            cur_py   <= mom_y;
            cur_pz   <= mom_z;
            cur_last <= last_in_event;
            slot     <= kept_total[SW-1:0];
            idx      <= '0;
            if (keep && !full) begin
              kept_total <= kept_total + CW'(1);
            end
            if (keep && full) begin
              overflow_seen <= 1'b1;
            end
            if (has_pairs) begin
              state <= cpim_pkg::ST_READ;
            end else if (last_in_event) begin
              state <= cpim_pkg::ST_SUMRY;
            end
          end
        end
        cpim_pkg::ST_READ: state <= cpim_pkg::ST_SUMS;
        cpim_pkg::ST_SUMS: begin
          et <= 17'(rd_e) + 17'(cur_e);
          sx <= 18'(rd_px) + 18'(cur_px);
          sy <= 18'(rd_py) + 18'(cur_py);
          sz <= 18'(rd_pz) + 18'(cur_pz);
          de <= (rd_e > cur_e) ? rd_e - cur_e : cur_e - rd_e;
          state <= cpim_pkg::ST_SQR;
        end
        cpim_pkg::ST_SQR: begin
          et2 <= et * et;
          sx2 <= 35'(sx * sx);
          sy2 <= 35'(sy * sy);
          sz2 <= 35'(sz * sz);
          state <= cpim_pkg::ST_ACC;
        end
        cpim_pkg::ST_ACC: begin
          m2 <= $signed({3'b000, et2}) - $signed({2'b00, sx2})
                - $signed({2'b00, sy2}) - $signed({2'b00, sz2});
          state <= cpim_pkg::ST_ROOT;
          step  <= '0;
        end
        cpim_pkg::ST_ROOT: begin
          if (step == '0) begin
            // load the radicand, clamped at zero; it always fits 34 bits
            rad  <= (m2 > 0) ? m2[33:0] : '0;
            rem  <= '0;
            root <= '0;
            step <= 5'd1;
          end else begin
            if (rem_sh >= trial) begin
              rem  <= rem_sh - trial;
              root <= {root[15:0], 1'b1};
            end else begin
              rem  <= rem_sh;
              root <= {root[15:0], 1'b0};
            end
            rad  <= {rad[31:0], 2'b00};
            step <= step + 5'd1;
            if (step == 5'(cpim_pkg::ROOT_STEPS)) begin
              state <= cpim_pkg::ST_DIV;
              step  <= '0;
            end
          end
        end
        cpim_pkg::ST_DIV: begin
          if (step == '0) begin
            inw  <= (root >= window_low) && (root <= window_high) && (et != '0);
            drem <= {2'b00, de};
            quo  <= '0;
            step <= 5'd1;
            if (!((root >= window_low) && (root <= window_high) && (et != '0))) begin
              state <= cpim_pkg::ST_EMIT;
            end
          end else begin
            if (dtrial >= {1'b0, et}) begin
              drem <= dtrial - {1'b0, et};
              quo  <= {quo[15:0], 1'b1};
            end else begin
              drem <= dtrial;
              quo  <= {quo[15:0], 1'b0};
            end
            step <= step + 5'd1;
            if (step == 5'(cpim_pkg::DIV_STEPS)) begin
              state <= cpim_pkg::ST_EMIT;
            end
          end
        end
        cpim_pkg::ST_EMIT: begin
          result_valid <= 1'b1;
          kind         <= cpim_pkg::KIND_PAIR;
          pair_mass    <= root;
          in_window    <= inw;
          asymmetry    <= !inw ? 16'd0 : (quo[16] ? 16'hFFFF : quo[15:0]);
          first_slot   <= 5'(idx);
          second_slot  <= 5'(slot);
          kept_count   <= '0;
          overflow     <= 1'b0;
          last         <= (idx == slot - SW'(1)) && !cur_last;
          idx          <= idx + SW'(1);
          if (idx == slot - SW'(1)) begin
            state <= cur_last ? cpim_pkg::ST_SUMRY : cpim_pkg::ST_IDLE;
          end else begin
            state <= cpim_pkg::ST_READ;
          end
        end
        cpim_pkg::ST_SUMRY: begin
          result_valid  <= 1'b1;
          kind          <= cpim_pkg::KIND_SUMMARY;
          pair_mass     <= '0;
          in_window     <= 1'b0;
          asymmetry     <= '0;
          first_slot    <= '0;
          second_slot   <= '0;
          kept_count    <= 6'(kept_total);
          overflow      <= overflow_seen;
          last          <= 1'b1;
          kept_total    <= '0;
          overflow_seen <= 1'b0;
          state         <= cpim_pkg::ST_IDLE;
        end
        default: state <= cpim_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/cpim_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpim_checker
// Port-level checks on the result stream of the pair mass finder.
// ----------------------------------------------------------------------------
`include "cluster_pair_invariant_mass_defines.svh"

module cpim_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        result_valid,
  input logic        kind,
  input logic        in_window,
  input logic [15:0] asymmetry,
  input logic [4:0]  first_slot,
  input logic [4:0]  second_slot,
  input logic        last
);

  `CPIM_ASSERT_SAME(a_summary_last, result_valid && kind, last, "summary not marked last")
  `CPIM_ASSERT_SAME(a_slot_order, result_valid && !kind, first_slot < second_slot, "slot order")
  `CPIM_ASSERT_SAME(a_asym_zero, result_valid && !in_window, asymmetry == '0, "asym outside window")
  // more results to come for this item, so the block stays busy
  `CPIM_ASSERT_SAME(a_busy_mid, result_valid && !last, busy, "idle before last result")
  `CPIM_ASSERT_NEXT(a_gap_after_last, result_valid && last, !result_valid, "result after last")

endmodule

bind cluster_pair_invariant_mass cpim_checker u_cpim_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .kind         (kind),
  .in_window    (in_window),
  .asymmetry    (asymmetry),
  .first_slot   (first_slot),
  .second_slot  (second_slot),
  .last         (last)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the cluster pair mass finder against an in-bench predictor of pair
// masses, window flags, asymmetry and event summaries, under random gaps.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic        cv;
    logic [15:0] e;
    logic [16:0] px, py, pz;
    logic        lie;
  } cluster_t;

  typedef struct packed {
    logic        kind;
    logic [16:0] mass;
    logic        inw;
    logic [15:0] asym;
    logic [4:0]  s1, s2;
    logic [5:0]  cnt;
    logic        ovf;
    logic        last;
  } outcome_t;

  logic clk = 0, rst = 1;
  logic wr_en = 0;
  logic [1:0] wr_index = '0;
  logic [16:0] wr_data = '0;
  logic start = 0, busy;
  logic cluster_valid = 0, last_in_event = 0;
  logic [15:0] energy = '0;
  logic signed [16:0] mom_x = '0, mom_y = '0, mom_z = '0;
  logic result_valid, kind, in_window, overflow, last;
  logic [16:0] pair_mass;
  logic [15:0] asymmetry;
  logic [4:0] first_slot, second_slot;
  logic [5:0] kept_count;

  cluster_pair_invariant_mass u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [15:0] cfg_min_e;
  logic [16:0] cfg_wlo, cfg_whi;
  logic [15:0] st_e [cpim_pkg::MAX_CLUSTERS];
  logic signed [16:0] st_x [cpim_pkg::MAX_CLUSTERS];
  logic signed [16:0] st_y [cpim_pkg::MAX_CLUSTERS];
  logic signed [16:0] st_z [cpim_pkg::MAX_CLUSTERS];
  int kept_n;
  bit ovf_seen;

  cluster_t pending_q [$];
  outcome_t expected_q [$];
  bit failed = 0;
  bit feeding = 0;
  int burst_left = 0, gap_left = 0;
  longint cycles = 0;

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_cluster(cluster_t c);
    outcome_t o;
    longint et, sx, sy, sz, m2, d;
    longint unsigned mass, asym;
    int n0;
    n0 = expected_q.size();
    if (c.cv && c.e >= cfg_min_e) begin
      if (kept_n < cpim_pkg::MAX_CLUSTERS) begin
        for (int i = 0; i < kept_n; i++) begin
          et = longint'(st_e[i]) + longint'(c.e);
          sx = longint'(st_x[i]) + longint'($signed(c.px));
          sy = longint'(st_y[i]) + longint'($signed(c.py));
          sz = longint'(st_z[i]) + longint'($signed(c.pz));
          m2 = et * et - sx * sx - sy * sy - sz * sz;
          mass = (m2 > 0) ? root_floor(m2) : 0;
          o = '0;
          o.kind = cpim_pkg::KIND_PAIR;
          o.mass = mass[16:0];
          o.inw = (mass >= cfg_wlo && mass <= cfg_whi && et > 0);
          if (o.inw) begin
            d = (st_e[i] > c.e) ? st_e[i] - c.e : c.e - st_e[i];
            asym = (d << 16) / et;
            o.asym = (asym > 65535) ? 16'hFFFF : asym[15:0];
          end
          o.s1 = 5'(i);
          o.s2 = 5'(kept_n);
          expected_q.insert(expected_q.size(), o);
        end
        st_e[kept_n] = c.e;
        st_x[kept_n] = c.px;
        st_y[kept_n] = c.py;
        st_z[kept_n] = c.pz;
        kept_n++;
      end else ovf_seen = 1;
    end
    if (c.lie) begin
      o = '0;
      o.kind = cpim_pkg::KIND_SUMMARY;
      o.cnt = 6'(kept_n);
      o.ovf = ovf_seen;
      expected_q.insert(expected_q.size(), o);
      kept_n = 0;
      ovf_seen = 0;
    end
    if (expected_q.size() > n0) expected_q[$].last = 1;
  endtask

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) predict_cluster({cluster_valid, energy, mom_x, mom_y, mom_z,
                                           last_in_event});
      if (!(start && busy)) begin
        if (feeding && pending_q.size() > 0 && gap_left == 0) begin
          cluster_t c;
          c = pending_q.pop_front();
          start <= 1;
          {cluster_valid, energy, mom_x, mom_y, mom_z, last_in_event} <= c;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else burst_left--;
        end else begin
          start <= 0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && result_valid) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        failed = 1;
      end else begin
        outcome_t x;
        x = expected_q.pop_front();
        if (kind !== x.kind) begin $error("kind exp %0d got %0d", x.kind, kind); failed = 1; end
        if (pair_mass !== x.mass) begin
          $error("pair_mass exp %0d got %0d", x.mass, pair_mass); failed = 1;
        end
        if (in_window !== x.inw) begin
          $error("in_window exp %0d got %0d", x.inw, in_window); failed = 1;
        end
        if (asymmetry !== x.asym) begin
          $error("asymmetry exp %0d got %0d", x.asym, asymmetry); failed = 1;
        end
        if (first_slot !== x.s1) begin
          $error("first_slot exp %0d got %0d", x.s1, first_slot); failed = 1;
        end
        if (second_slot !== x.s2) begin
          $error("second_slot exp %0d got %0d", x.s2, second_slot); failed = 1;
        end
        if (kept_count !== x.cnt) begin
          $error("kept_count exp %0d got %0d", x.cnt, kept_count); failed = 1;
        end
        if (overflow !== x.ovf) begin
          $error("overflow exp %0d got %0d", x.ovf, overflow); failed = 1;
        end
        if (last !== x.last) begin $error("last exp %0d got %0d", x.last, last); failed = 1; end
      end
    end
  end

  function automatic cluster_t mk(int cv, int e, int x, int y, int z, int lie);
    cluster_t c;
    c = {1'(cv), 16'(e), 17'(x), 17'(y), 17'(z), 1'(lie)};
    return c;
  endfunction

  function automatic logic [16:0] rnd_mom(int span);
    int v;
    case ($urandom_range(0, 5))
      0: v = -65536;
      1: v = 65535;
      2: v = $urandom_range(0, 131071) - 65536;
      default: v = int'($urandom_range(0, 2 * span)) - span;
    endcase
    return v[16:0];
  endfunction

  task automatic wait_idle();
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (start || busy || expected_q.size() > 0) @(posedge clk);
    // drop-only items leave no result to wait on
    repeat (1200) @(posedge clk);
    feeding = 0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(posedge clk);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 0;
    if (idx == cpim_pkg::REG_MIN_ENERGY) cfg_min_e = val[15:0];
    else if (idx == cpim_pkg::REG_WINDOW_LOW) cfg_wlo = val;
    else if (idx == cpim_pkg::REG_WINDOW_HIGH) cfg_whi = val;
  endtask

  task automatic random_events(int items, int span);
    int left, len;
    left = items;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 7);
      for (int k = 0; k < len && left > 0; k++, left--) begin
        int e;
        e = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) :
            $urandom_range(0, 2 * span);
        pending_q.insert(pending_q.size(),
                         mk($urandom_range(0, 11) != 0, e, rnd_mom(span), rnd_mom(span),
                            rnd_mom(span), (k == len - 1) || ($urandom_range(0, 15) == 0)));
      end
    end
    feeding = 1;
    wait_idle();
  endtask

  initial begin
    cfg_min_e = cpim_pkg::MIN_ENERGY_RST;
    cfg_wlo = cpim_pkg::WINDOW_LOW_RST;
    cfg_whi = cpim_pkg::WINDOW_HIGH_RST;
    kept_n = 0;
    ovf_seen = 0;
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: resting mass, extremes, below-threshold energy, marker without end
    pending_q.insert(pending_q.size(), mk(1, 70, 0, 0, 0, 0));
    pending_q.insert(pending_q.size(), mk(1, 70, 0, 0, 0, 0));
    pending_q.insert(pending_q.size(), mk(1, 65535, 17'h10000, 17'h0FFFF, 17'h10000, 0));
    pending_q.insert(pending_q.size(), mk(1, 69, 5, 5, 5, 0));
    pending_q.insert(pending_q.size(), mk(0, 300, 0, 0, 0, 0));
    pending_q.insert(pending_q.size(), mk(1, 65535, 17'h0FFFF, 17'h10000, 17'h0FFFF, 1));
    pending_q.insert(pending_q.size(), mk(0, 0, 0, 0, 0, 1));
    feeding = 1;
    wait_idle();
    write_reg(cpim_pkg::REG_MIN_ENERGY, 17'd0);
    write_reg(cpim_pkg::REG_UNUSED, 17'h1FFFF);
    write_reg(cpim_pkg::REG_WINDOW_LOW, 17'd0);
    write_reg(cpim_pkg::REG_WINDOW_HIGH, 17'h1FFFF);
    // zero energies, one-sided energy saturates asymmetry
    pending_q.insert(pending_q.size(), mk(1, 0, 0, 0, 0, 0));
    pending_q.insert(pending_q.size(), mk(1, 0, 0, 0, 0, 0));
    pending_q.insert(pending_q.size(), mk(1, 100, 0, 0, 0, 0));
    pending_q.insert(pending_q.size(), mk(1, 65535, 0, 0, 0, 1));
    // store full: 34 clusters in one event
    for (int i = 0; i < 34; i++)
      pending_q.insert(pending_q.size(), mk(1, 1000 + i, i, -i, 0, i == 33));
    feeding = 1;
    wait_idle();
    write_reg(cpim_pkg::REG_WINDOW_LOW, 17'd500);
    write_reg(cpim_pkg::REG_WINDOW_HIGH, 17'd400);  // inverted window
    random_events(60, 400);
    write_reg(cpim_pkg::REG_MIN_ENERGY, 17'd100);
    write_reg(cpim_pkg::REG_WINDOW_LOW, 17'd50);
    write_reg(cpim_pkg::REG_WINDOW_HIGH, 17'd600);
    random_events(200, 300);
    write_reg(cpim_pkg::REG_MIN_ENERGY, 17'h0FFFF);
    write_reg(cpim_pkg::REG_WINDOW_LOW, 17'd0);
    write_reg(cpim_pkg::REG_WINDOW_HIGH, 17'h1FFFF);
    random_events(30, 40000);
    write_reg(cpim_pkg::REG_MIN_ENERGY, 17'd10);
    random_events(90, 30000);

    if (!failed) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- cluster_pair_invariant_mass.f -----
+incdir+hw/rtl
hw/rtl/cpim_pkg.sv
hw/rtl/cpim_ram.sv
hw/rtl/cluster_pair_invariant_mass.sv
hw/rtl/cpim_checker.sv
test/testbench.sv
